FILE: design/sevseg_pkg.sv
// Package for the two-counter seven-segment framer.
// Holds the command bytes, byte slot codes, segment types and the digit-to-segment map.
// No dependencies.
`default_nettype none

package sevseg_pkg;

    localparam logic [7:0] DATA_CMD  = 8'h40;   // auto-increment data command
    localparam logic [7:0] ADDR_CMD  = 8'hC0;   // address of first digit
    localparam logic [6:0] MAX_COUNT = 7'd99;

    // byte slots within one six-byte run
    localparam logic [2:0] SLOT_DATA     = 3'd0;
    localparam logic [2:0] SLOT_ADDR     = 3'd1;
    localparam logic [2:0] SLOT_L_TENS   = 3'd2;
    localparam logic [2:0] SLOT_L_UNITS  = 3'd3;
    localparam logic [2:0] SLOT_R_TENS   = 3'd4;
    localparam logic [2:0] SLOT_R_UNITS  = 3'd5;

    typedef struct packed {
        logic [7:0] tens;
        logic [7:0] units;
    } digit_seg_t;

    typedef struct packed {
        digit_seg_t left_pair;
        digit_seg_t right_pair;
    } seg_set_t;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

FILE: design/sevseg_lane.sv
// One digit-pair lane: saturates a count, splits it into tens and units, maps to segments.
// Depends on sevseg_pkg.
`default_nettype none

module sevseg_lane (
    input  wire logic [6:0]            count,
    output sevseg_pkg::digit_seg_t     segs
);

    logic [6:0]  clamped;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  units_wide;
    logic [3:0]  units;

    assign clamped    = (count > sevseg_pkg::MAX_COUNT) ? sevseg_pkg::MAX_COUNT : count;
    // c/10 as (c*205)>>11, exact for c <= 99
    assign prod       = 15'(clamped) * 15'd205;
    assign tens       = prod[14:11];
    assign tens_x10   = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
    assign units_wide = clamped - tens_x10;
    assign units      = units_wide[3:0];

    // leading zero blanks
    assign segs.tens  = (tens == 4'd0) ? 8'h00 : sevseg_pkg::seg_of(tens);
    assign segs.units = sevseg_pkg::seg_of(units);

endmodule

`default_nettype wire

FILE: design/sevseg_merge.sv
// Merging stage: holds the segment bytes of one update and emits the six-byte run.
// Depends on sevseg_pkg.
`default_nettype none

module sevseg_merge (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire sevseg_pkg::seg_set_t  segs,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 frame_byte,
    output logic                       start_before,
    output logic                       stop_after,
    output logic                       last
);

    logic                 busy_reg, busy_next;
    logic [2:0]           idx_reg, idx_next;
    sevseg_pkg::seg_set_t segs_reg, segs_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 start_reg, start_next;
    logic                 stop_reg, stop_next;
    logic                 last_reg, last_next;

    logic load;
    logic fin;
    logic accept;

    assign load     = busy_reg && (!out_valid_reg || out_ready);
    assign fin      = load && (idx_reg == sevseg_pkg::SLOT_R_UNITS);
    // next update may enter on the cycle the last byte moves to the output
    assign in_ready = !busy_reg || fin;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        busy_next      = accept ? 1'b1 : (fin ? 1'b0 : busy_reg);
        idx_next       = accept ? 3'd0 : (load ? idx_reg + 3'd1 : idx_reg);
        segs_next      = accept ? segs : segs_reg;
        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

        byte_next  = byte_reg;
        start_next = start_reg;
        stop_next  = stop_reg;
        last_next  = last_reg;
        if (load)
        begin
            start_next = 1'b0;
            stop_next  = 1'b0;
            last_next  = 1'b0;
            unique case (idx_reg)
                sevseg_pkg::SLOT_DATA:
                begin
                    byte_next  = sevseg_pkg::DATA_CMD;
                    start_next = 1'b1;
                    stop_next  = 1'b1;
                end
                sevseg_pkg::SLOT_ADDR:
                begin
                    byte_next  = sevseg_pkg::ADDR_CMD;
                    start_next = 1'b1;
                end
                sevseg_pkg::SLOT_L_TENS:  byte_next = segs_reg.left_pair.tens;
                sevseg_pkg::SLOT_L_UNITS: byte_next = segs_reg.left_pair.units;
                sevseg_pkg::SLOT_R_TENS:  byte_next = segs_reg.right_pair.tens;
                sevseg_pkg::SLOT_R_UNITS:
                begin
                    byte_next = segs_reg.right_pair.units;
                    stop_next = 1'b1;
                    last_next = 1'b1;
                end
                default:                  byte_next = byte_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= sevseg_pkg::SLOT_DATA;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        segs_reg  <= segs_next;
        byte_reg  <= byte_next;
        start_reg <= start_next;
        stop_reg  <= stop_next;
        last_reg  <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign frame_byte   = byte_reg;
    assign start_before = start_reg;
    assign stop_after   = stop_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

FILE: design/two_counter_seven_segment_framer.sv
// Top level of the two-counter seven-segment framer: two digit lanes and the merging stage.
// Depends on sevseg_pkg, sevseg_lane and sevseg_merge.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------------
//   input    | in_valid / in_ready  | left_count, right_count
//   output   | out_valid / out_ready| frame_byte, start_before, stop_after, last
//
// Each update produces six output transfers, one per cycle when out_ready stays high;
// the six-slot byte counter in the merge stage steps through them.
// After the input transfer the first byte goes through the busy flag, then the output register.
// The next update is accepted in the cycle the sixth byte enters the output register.
// Output stalls hold the run in place; reset clears the counter, the busy flag and the valid flag.
`default_nettype none

module two_counter_seven_segment_framer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [6:0] left_count,
    input  wire logic [6:0] right_count,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      frame_byte,
    output logic            start_before,
    output logic            stop_after,
    output logic            last
);

    sevseg_pkg::seg_set_t lane_segs;

    sevseg_lane u_lane_left (
        .count (left_count),
        .segs  (lane_segs.left_pair)
    );

    sevseg_lane u_lane_right (
        .count (right_count),
        .segs  (lane_segs.right_pair)
    );

    sevseg_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .segs         (lane_segs),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_byte   (frame_byte),
        .start_before (start_before),
        .stop_after   (stop_after),
        .last         (last)
    );

`ifndef NO_ASSERTIONS
    // an accepted update has a byte waiting on the output once the busy flag and then the output register are loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("no output byte after input transfer");

    // a start without stop is always the address frame opener
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_before && !stop_after |-> frame_byte == sevseg_pkg::ADDR_CMD)
        else $error("address frame opener corrupted");

    // last byte closes the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> stop_after && !start_before)
        else $error("last byte without stop");
`endif

endmodule

`default_nettype wire
